// File: design/pvi_pkg.sv
`timescale 1ns / 1ps
package pvi_pkg;
    localparam int FRAC_BITS      = 16;
    localparam int TIMESTEP_SHIFT = 6;
    localparam int NUM_LANES      = 3;

    localparam logic [2:0] KIND_STEP      = 3'd0;
    localparam logic [2:0] KIND_WAKE      = 3'd1;
    localparam logic [2:0] KIND_SLEEP     = 3'd2;
    localparam logic [2:0] KIND_SET_VEL   = 3'd3;
    localparam logic [2:0] KIND_FORCE_VEL = 3'd4;
    localparam logic [2:0] KIND_FORCE_POS = 3'd5;
    localparam logic [2:0] KIND_FORCE_ACC = 3'd6;

    localparam logic [2:0] REG_INV_MASS  = 3'd0;
    localparam logic [2:0] REG_DRAG      = 3'd1;
    localparam logic [2:0] REG_BIAS      = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_GRAV_X    = 3'd4;
    localparam logic [2:0] REG_GRAV_Y    = 3'd5;
    localparam logic [2:0] REG_GRAV_Z    = 3'd6;
    localparam logic [2:0] REG_MODE      = 3'd7;

    // Lane operation phases, one multiply in each phase but the idle one.
    localparam logic [1:0] LPH_IDLE  = 2'd0;
    localparam logic [1:0] LPH_ACCEL = 2'd1;
    localparam logic [1:0] LPH_DRAG  = 2'd2;
    localparam logic [1:0] LPH_SQ    = 2'd3;

    // Motion merge steps.
    localparam logic [1:0] MPH_IDLE   = 2'd0;
    localparam logic [1:0] MPH_REDUCE = 2'd1;
    localparam logic [1:0] MPH_WEIGHT = 2'd2;
    localparam logic [1:0] MPH_DECIDE = 2'd3;

    typedef struct packed {
        logic [1:0] phase;
        logic       load;
    } t_lane_ctrl;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -72'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

// File: design/pvi_lane.sv
`timescale 1ns / 1ps
// One axis of the integrator: position, velocity and acceleration of that axis.
module pvi_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pvi_pkg::t_lane_ctrl   i_ctrl,
    input  logic signed [31:0]    i_force,
    input  logic signed [31:0]    i_grav,
    input  logic                  i_use_grav,
    input  logic [31:0]           i_inv_mass,
    input  logic [16:0]           i_drag,
    input  logic                  i_wr_pos,
    input  logic                  i_wr_vel,
    input  logic                  i_wr_acc,
    input  logic                  i_zero_vel,
    input  logic signed [31:0]    i_operand,
    output logic signed [31:0]    o_pos,
    output logic signed [31:0]    o_vel,
    output logic [63:0]           o_sq
);
    logic signed [31:0] r_pos, r_vel, r_acc, r_force, r_vtmp;
    logic [63:0]        r_sq;
    logic signed [33:0] w_f;
    logic signed [71:0] w_t, w_p, w_m, w_v;
    logic signed [33:0] w_a;
    logic signed [31:0] w_anew;

    always_comb begin
        w_f = 34'(i_force) + (i_use_grav ? 34'(i_grav) : 34'sd0);
        w_t = (72'(r_vel) <<< (pvi_pkg::TIMESTEP_SHIFT + 1)) + 72'(r_acc);
        w_p = 72'(r_pos) + (w_t >>> (2 * pvi_pkg::TIMESTEP_SHIFT + 1));
        w_m = 72'(r_force) * $signed({40'd0, i_inv_mass});
        w_anew = pvi_pkg::sat32(w_m >>> pvi_pkg::FRAC_BITS);
        w_a = 34'(r_acc) + 34'(w_anew);
        w_v = 72'(r_vel) + 72'(w_a >>> (pvi_pkg::TIMESTEP_SHIFT + 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_acc <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_force <= pvi_pkg::sat32(72'(w_f));
            end
            unique case (i_ctrl.phase)
                pvi_pkg::LPH_ACCEL: begin
                    r_pos  <= pvi_pkg::sat32(w_p);
                    r_acc  <= w_anew;
                    r_vtmp <= pvi_pkg::sat32(w_v);
                end
                pvi_pkg::LPH_DRAG: begin
                    r_vel <= pvi_pkg::sat32((72'(r_vtmp) * $signed({55'd0, i_drag}))
                                            >>> pvi_pkg::FRAC_BITS);
                end
                pvi_pkg::LPH_SQ: begin
                    r_sq <= 64'(72'(r_vel) * 72'(r_vel));
                end
                default: ;
            endcase
            if (i_wr_pos) r_pos <= i_operand;
            if (i_wr_acc) r_acc <= i_operand;
            if (i_wr_vel) r_vel <= i_operand;
            if (i_zero_vel) r_vel <= '0;
        end
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_sq  = r_sq;
endmodule

// File: design/pvi_merge.sv
`timescale 1ns / 1ps
// Combines the lane squares into the motion average and makes the sleep decision.
module pvi_merge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_step,
    input  logic [63:0] i_sq0,
    input  logic [63:0] i_sq1,
    input  logic [63:0] i_sq2,
    input  logic [16:0] i_bias,
    input  logic [31:0] i_thresh,
    input  logic        i_wake,
    output logic        o_fall_asleep
);
    logic [31:0]        r_motion, r_vv;
    logic signed [68:0] r_m;
    logic [63:0]        w_sum;
    logic [35:0]        w_cap10;
    logic [32:0]        w_cap2;
    logic signed [68:0] w_msh;
    logic [31:0]        w_mcl;

    always_comb begin
        w_sum   = i_sq0 + i_sq1 + i_sq2;
        w_cap10 = 36'(i_thresh) * 36'd10;
        w_cap2  = {i_thresh, 1'b0};
        w_msh   = r_m >>> pvi_pkg::FRAC_BITS;
        if (w_msh < 0) w_mcl = '0;
        else if (w_msh > 69'sd4294967295) w_mcl = 32'hFFFFFFFF;
        else w_mcl = w_msh[31:0];
        o_fall_asleep = (i_step == pvi_pkg::MPH_DECIDE) && (w_mcl < i_thresh);
    end

    // Step 1 reduces the squares, step 2 does the two weighted products, step 3 decides.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion <= 32'(30 << pvi_pkg::FRAC_BITS);
        end else if (i_wake) begin
            r_motion <= w_cap2[32] ? 32'hFFFFFFFF : w_cap2[31:0];
        end else begin
            unique case (i_step)
                pvi_pkg::MPH_REDUCE: r_vv <= ((w_sum >> pvi_pkg::FRAC_BITS) > 64'hFFFFFFFF)
                                            ? 32'hFFFFFFFF : 32'(w_sum >> pvi_pkg::FRAC_BITS);
                pvi_pkg::MPH_WEIGHT: r_m <= 69'($signed({1'b0, i_bias}))
                                            * 69'($signed({1'b0, r_motion}))
                                          + (69'($signed(18'(1 << pvi_pkg::FRAC_BITS)))
                                             - 69'($signed({1'b0, i_bias})))
                                            * 69'($signed({1'b0, r_vv}));
                pvi_pkg::MPH_DECIDE: begin
                    if (w_mcl >= i_thresh && 36'(w_mcl) > w_cap10)
                        r_motion <= (w_cap10 > 36'hFFFFFFFF) ? 32'hFFFFFFFF : w_cap10[31:0];
                    else
                        r_motion <= w_mcl;
                end
                default: ;
            endcase
        end
    end
endmodule

// File: design/particle_verlet_integrator.sv
`timescale 1ns / 1ps
// Particle Verlet integrator, one particle in Q16.16.
// Input channel (s_axis): tuser carries the item kind, tdata the operand vector.
// A step item integrates with the force in tdata; other kinds wake, sleep or
// overwrite velocity, position or acceleration.
// Output channel (m_axis): one transaction per input transaction with the moved
// and awake flags in tuser and the resulting position and velocity in tdata.
// A non-step item, or a step of an asleep or immovable particle, passes from
// acceptance through the accelerate state to the output state; a step without
// the motion update adds the drag phase, and a full step the drag and square
// phases of the three axis lanes and the reduce, weight and decide steps of the
// motion merge; the output register is loaded from the output state.
// One item is in work at a time; the next waits until the last is registered out.
// The output register holds its transaction while m_axis_tready is low; one more
// item is taken meanwhile and waits, finished, until the register is free.
// Reset puts the configuration and control registers to their reset values, the
// particle awake at rest at the origin. Configuration goes through the APB port,
// registers at byte address 4*i.
module particle_verlet_integrator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,   // operand_x, operand_y, operand_z
    input  logic [2:0]    s_axis_tuser,   // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic [1:0]    m_axis_tuser,   // moved, is_awake
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_ACC = 3'd1, ST_DRAG = 3'd2, ST_SQ = 3'd3,
                           ST_M1 = 3'd4, ST_M2 = 3'd5, ST_M3 = 3'd6, ST_OUT = 3'd7;

    logic [31:0] r_inv_mass, r_thresh, r_gx, r_gy, r_gz;
    logic [16:0] r_drag, r_bias;
    logic [2:0]  r_mode, r_state, r_kind;
    logic [95:0] r_opnd;
    logic        r_awake, r_moved, r_ovalid;
    logic [191:0] r_odata;
    logic [1:0]  r_ouser;

    pvi_pkg::t_lane_ctrl w_ctrl;
    logic        w_acc, w_wr, w_step_go, w_fall, w_wake, w_out_go;
    logic [1:0]  w_mstep;
    logic signed [31:0] w_pos [3], w_vel [3];
    logic [63:0] w_sq [3];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    // A finished item moves to the output register once that register is free.
    assign w_out_go = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);

    always_comb begin
        unique case (paddr[4:2])
            pvi_pkg::REG_INV_MASS:  prdata = r_inv_mass;
            pvi_pkg::REG_DRAG:      prdata = {15'd0, r_drag};
            pvi_pkg::REG_BIAS:      prdata = {15'd0, r_bias};
            pvi_pkg::REG_THRESHOLD: prdata = r_thresh;
            pvi_pkg::REG_GRAV_X:    prdata = r_gx;
            pvi_pkg::REG_GRAV_Y:    prdata = r_gy;
            pvi_pkg::REG_GRAV_Z:    prdata = r_gz;
            pvi_pkg::REG_MODE:      prdata = {29'd0, r_mode};
            default:                prdata = '0;
        endcase
    end

    always_comb begin
        w_step_go = (r_kind == pvi_pkg::KIND_STEP) && (r_inv_mass != 0) && r_awake;
        w_ctrl.load = w_acc;
        unique case (r_state)
            ST_ACC:  w_ctrl.phase = pvi_pkg::LPH_ACCEL;
            ST_DRAG: w_ctrl.phase = pvi_pkg::LPH_DRAG;
            ST_SQ:   w_ctrl.phase = pvi_pkg::LPH_SQ;
            default: w_ctrl.phase = pvi_pkg::LPH_IDLE;
        endcase
        unique case (r_state)
            ST_M1:   w_mstep = pvi_pkg::MPH_REDUCE;
            ST_M2:   w_mstep = pvi_pkg::MPH_WEIGHT;
            ST_M3:   w_mstep = pvi_pkg::MPH_DECIDE;
            default: w_mstep = pvi_pkg::MPH_IDLE;
        endcase
        w_wake = (r_state == ST_ACC) && (r_kind == pvi_pkg::KIND_WAKE);
    end

    // Non-step items commit in the ST_ACC cycle; kinds are decoded once there.
    logic w_commit;
    assign w_commit = (r_state == ST_ACC);

    genvar g;
    generate
        for (g = 0; g < pvi_pkg::NUM_LANES; g++) begin : g_lane
            logic [31:0] w_grav;
            assign w_grav = (g == 0) ? r_gx : ((g == 1) ? r_gy : r_gz);
            pvi_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (pvi_pkg::t_lane_ctrl'{phase: (w_step_go ? w_ctrl.phase
                                                  : pvi_pkg::LPH_IDLE), load: w_ctrl.load}),
                .i_force   ($signed(s_axis_tdata[32*g +: 32])),
                .i_grav    ($signed(w_grav)),
                .i_use_grav(r_mode[0]),
                .i_inv_mass(r_inv_mass),
                .i_drag    (r_drag),
                .i_wr_pos  (w_commit && r_kind == pvi_pkg::KIND_FORCE_POS),
                .i_wr_vel  (w_commit && (r_kind == pvi_pkg::KIND_FORCE_VEL ||
                            (r_kind == pvi_pkg::KIND_SET_VEL && r_mode[2]))),
                .i_wr_acc  (w_commit && r_kind == pvi_pkg::KIND_FORCE_ACC),
                .i_zero_vel((w_commit && r_kind == pvi_pkg::KIND_SLEEP) || w_fall),
                .i_operand ($signed(r_opnd[32*g +: 32])),
                .o_pos     (w_pos[g]),
                .o_vel     (w_vel[g]),
                .o_sq      (w_sq[g])
            );
        end
    endgenerate

    pvi_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_mstep),
        .i_sq0        (w_sq[0]),
        .i_sq1        (w_sq[1]),
        .i_sq2        (w_sq[2]),
        .i_bias       (r_bias),
        .i_thresh     (r_thresh),
        .i_wake       (w_wake),
        .o_fall_asleep(w_fall)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass <= 32'h0001_0000;
            r_drag     <= 17'h10000;
            r_bias     <= 17'h08000;
            r_thresh   <= 32'd19661;
            r_gx       <= '0;
            r_gy       <= 32'hFFF6_3333;
            r_gz       <= '0;
            r_mode     <= 3'd7;
            r_state    <= ST_IDLE;
            r_awake    <= 1'b1;
            r_moved    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_kind     <= '0;
        end else begin
            if (w_wr) begin
                unique case (paddr[4:2])
                    pvi_pkg::REG_INV_MASS:  r_inv_mass <= pwdata;
                    pvi_pkg::REG_DRAG:      r_drag     <= pwdata[16:0];
                    pvi_pkg::REG_BIAS:      r_bias     <= pwdata[16:0];
                    pvi_pkg::REG_THRESHOLD: r_thresh   <= pwdata;
                    pvi_pkg::REG_GRAV_X:    r_gx       <= pwdata;
                    pvi_pkg::REG_GRAV_Y:    r_gy       <= pwdata;
                    pvi_pkg::REG_GRAV_Z:    r_gz       <= pwdata;
                    pvi_pkg::REG_MODE:      r_mode     <= pwdata[2:0];
                    default: ;
                endcase
            end
            if (w_out_go) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (w_acc) begin
                    r_kind  <= s_axis_tuser;
                    r_opnd  <= s_axis_tdata;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_moved <= w_step_go;
                    if (r_kind == pvi_pkg::KIND_WAKE) r_awake <= 1'b1;
                    if (r_kind == pvi_pkg::KIND_SLEEP) r_awake <= 1'b0;
                    r_state <= w_step_go ? ST_DRAG : ST_OUT;
                end
                ST_DRAG: r_state <= r_mode[1] ? ST_SQ : ST_OUT;
                ST_SQ:   r_state <= ST_M1;
                ST_M1:   r_state <= ST_M2;
                ST_M2:   r_state <= ST_M3;
                ST_M3: begin
                    if (w_fall) r_awake <= 1'b0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_go) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_go) begin
            r_odata <= {w_vel[2], w_vel[1], w_vel[0], w_pos[2], w_pos[1], w_pos[0]};
            r_ouser <= {r_awake, r_moved};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
endmodule

// File: design/pvi_checker.sv
`timescale 1ns / 1ps
module pvi_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("output changed while stalled");
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("second item taken while busy");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({s_axis_tready, m_axis_tvalid}))
        else $error("handshake signal unknown");
endmodule

bind particle_verlet_integrator pvi_checker u_pvi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import pvi_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int CYCLE_CAP  = 400000;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_LEN  = 115;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [95:0]   s_axis_tdata = '0;   // operand_x, operand_y, operand_z
    logic [2:0]    s_axis_tuser = '0;   // kind
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [191:0]  m_axis_tdata;        // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    logic [1:0]    m_axis_tuser;        // moved, is_awake
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    particle_verlet_integrator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // One particle command as it travels on the input channel.
    typedef struct packed {
        logic [2:0]  kind;
        logic [95:0] operands;
    } t_particle_cmd;

    // One particle state snapshot as it should appear on the output channel.
    typedef struct packed {
        logic [1:0]   flags;
        logic [191:0] state;
    } t_particle_snap;

    t_particle_cmd  cmd_queue[$];
    t_particle_snap snap_queue[$];

    // Register file copy, held at full precision for the arithmetic.
    longint inv_mass, drag, bias, threshold, mode;
    longint grav[3];

    // Particle copy.
    longint pos[3], vel[3], acc[3];
    longint motion;
    bit     awake;

    int mismatches = 0;
    int cycles = 0;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_u32(input longint v);
        return (v > 64'sd4294967295) ? 64'sd4294967295 : v;
    endfunction

    function automatic longint word_signed(input logic [31:0] w);
        return longint'(signed'(w));
    endfunction

    // Velocity Verlet advance for one step command. Returns the moved flag.
    function automatic bit advance_particle(input logic [95:0] ops);
        longint f, a_old, a_new, t, v, m, vv, cap;
        logic [65:0] sq;
        if (inv_mass == 0 || !awake) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            f = word_signed(ops[32*i +: 32]);
            if (mode[0]) f = f + grav[i];
            f = clip32(f);
            a_old = acc[i];
            t = vel[i] * (64'sd1 <<< (TIMESTEP_SHIFT + 1)) + a_old;
            pos[i] = clip32(pos[i] + (t >>> (2 * TIMESTEP_SHIFT + 1)));
            a_new = clip32((f * inv_mass) >>> FRAC_BITS);
            v = clip32(vel[i] + ((a_old + a_new) >>> (TIMESTEP_SHIFT + 1)));
            acc[i] = a_new;
            vel[i] = clip32((v * drag) >>> FRAC_BITS);
        end
        if (mode[1]) begin
            sq = '0;
            for (int i = 0; i < 3; i++) sq = sq + 66'(vel[i] * vel[i]);
            sq = sq >> FRAC_BITS;
            vv = (sq > 66'hFFFFFFFF) ? 64'sd4294967295 : longint'(sq);
            // A bias above one makes the second weight negative; the sum is
            // clamped back into range afterwards.
            m = bias * motion + ((64'sd1 <<< FRAC_BITS) - bias) * vv;
            m = m >>> FRAC_BITS;
            if (m < 0) m = 0;
            motion = clip_u32(m);
            cap = clip_u32(10 * threshold);
            if (motion < threshold) begin
                awake = 1'b0;
                for (int i = 0; i < 3; i++) vel[i] = 0;
            end else if (motion > 10 * threshold) begin
                motion = cap;
            end
        end
        return 1'b1;
    endfunction

    // Applies one command to the particle copy and queues the snapshot.
    task automatic predict_snapshot(input t_particle_cmd c);
        t_particle_snap s;
        bit moved;
        moved = 1'b0;
        case (c.kind)
            KIND_STEP:  moved = advance_particle(c.operands);
            KIND_WAKE: begin
                awake = 1'b1;
                motion = clip_u32(2 * threshold);
            end
            KIND_SLEEP: begin
                awake = 1'b0;
                for (int i = 0; i < 3; i++) vel[i] = 0;
            end
            KIND_SET_VEL: begin
                if (mode[2])
                    for (int i = 0; i < 3; i++) vel[i] = word_signed(c.operands[32*i +: 32]);
            end
            KIND_FORCE_VEL:
                for (int i = 0; i < 3; i++) vel[i] = word_signed(c.operands[32*i +: 32]);
            KIND_FORCE_POS:
                for (int i = 0; i < 3; i++) pos[i] = word_signed(c.operands[32*i +: 32]);
            KIND_FORCE_ACC:
                for (int i = 0; i < 3; i++) acc[i] = word_signed(c.operands[32*i +: 32]);
            default: ;
        endcase
        s.flags = {awake, moved};
        for (int i = 0; i < 3; i++) begin
            s.state[32*i +: 32]     = pos[i][31:0];
            s.state[96 + 32*i +: 32] = vel[i][31:0];
        end
        snap_queue.push_back(s);
    endtask

    // Driver: bursts of transactions separated by random gaps. The predictor
    // runs on the edge at which a transaction is accepted.
    int gap_left = 0;
    int burst_left = 4;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_snapshot({s_axis_tuser, s_axis_tdata});
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    {s_axis_tuser, s_axis_tdata} <= cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: the receiver stalls on a shifting pattern that is refreshed now
    // and then, sometimes to all ones so that long stall-free runs occur.
    logic [15:0] stall_pattern = 16'hFFFF;
    always @(posedge i_clk) begin
        t_particle_snap want;
        if ($urandom_range(0, 31) == 0)
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        else
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        m_axis_tready <= stall_pattern[0];
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (snap_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                want = snap_queue.pop_front();
                if (want.flags !== m_axis_tuser || want.state !== m_axis_tdata) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch flags(awake,moved) exp %b got %b", want.flags,
                                 m_axis_tuser);
                        for (int i = 0; i < 3; i++)
                            $display("  lane %0d pos exp %h got %h vel exp %h got %h", i,
                                     want.state[32*i +: 32], m_axis_tdata[32*i +: 32],
                                     want.state[96 + 32*i +: 32],
                                     m_axis_tdata[96 + 32*i +: 32]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Register write over APB; the bench copy follows on the same edge.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_INV_MASS:  inv_mass = longint'(value);
            REG_DRAG:      drag = longint'(value[16:0]);
            REG_BIAS:      bias = longint'(value[16:0]);
            REG_THRESHOLD: threshold = longint'(value);
            REG_GRAV_X:    grav[0] = word_signed(value);
            REG_GRAV_Y:    grav[1] = word_signed(value);
            REG_GRAV_Z:    grav[2] = word_signed(value);
            default:       mode = longint'(value[2:0]);
        endcase
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4, 5: return 32'($urandom_range(0, 32'h1FFFFF)) - 32'h100000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return KIND_STEP;
        if (r < 63) return KIND_WAKE;
        if (r < 67) return KIND_SLEEP;
        if (r < 75) return KIND_SET_VEL;
        if (r < 82) return KIND_FORCE_VEL;
        if (r < 89) return KIND_FORCE_POS;
        if (r < 96) return KIND_FORCE_ACC;
        return 3'd7;
    endfunction

    task automatic queue_cmd(input logic [2:0] kind, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        cmd_queue.push_back({kind, z, y, x});
    endtask

    // Waits until every queued command has gone through and its result has
    // come back, then leaves a few spare cycles.
    task automatic drain();
        while (cmd_queue.size() > 0 || s_axis_tvalid || snap_queue.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        inv_mass = 65536;
        drag = 65536;
        bias = 32768;
        threshold = 19661;
        grav[0] = 0;
        grav[1] = -642253;
        grav[2] = 0;
        mode = 7;
        for (int i = 0; i < 3; i++) begin
            pos[i] = 0;
            vel[i] = 0;
            acc[i] = 0;
        end
        motion = 30 * 65536;
        awake = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings.
        queue_cmd(KIND_STEP, 32'h0, 32'h0, 32'h0);
        queue_cmd(KIND_STEP, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        queue_cmd(KIND_FORCE_VEL, 32'h7FFFFFFF, 32'h80000000, 32'h0);
        queue_cmd(KIND_STEP, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        queue_cmd(KIND_FORCE_POS, 32'h7FFFFFF0, 32'h80000010, 32'h0);
        queue_cmd(KIND_FORCE_ACC, 32'h7FFFFFFF, 32'h80000000, 32'h12345);
        queue_cmd(KIND_STEP, 32'hFFFFFFFF, 32'h1, 32'h0);
        queue_cmd(KIND_SET_VEL, 32'h10000, 32'hFFFF0000, 32'h0);
        queue_cmd(KIND_SLEEP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        // An asleep particle does not move on a step.
        queue_cmd(KIND_STEP, 32'h10000, 32'h10000, 32'h10000);
        queue_cmd(KIND_WAKE, 32'h0, 32'h0, 32'h0);
        queue_cmd(KIND_WAKE, 32'h0, 32'h0, 32'h0);
        queue_cmd(KIND_FORCE_VEL, 32'h0, 32'h0, 32'h0);
        // Nearly still particle: the average decays below the threshold.
        for (int i = 0; i < 6; i++) queue_cmd(KIND_STEP, 32'h0, 32'h9CCCD, 32'h0);
        queue_cmd(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        queue_cmd(KIND_WAKE, 32'h0, 32'h0, 32'h0);
        // Fast particle: the average is clamped at ten times the threshold.
        queue_cmd(KIND_FORCE_VEL, 32'h00500000, 32'h0, 32'h0);
        queue_cmd(KIND_STEP, 32'h0, 32'h0, 32'h0);
        drain();

        // Gated velocity set is ignored with the override bit clear.
        write_reg(REG_MODE, 32'd3);
        queue_cmd(KIND_SET_VEL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_cmd(KIND_STEP, 32'h1000, 32'h2000, 32'h3000);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 0) begin
                // Immovable particle, zero drag and bias, zero threshold.
                write_reg(REG_INV_MASS, 32'h0);
                write_reg(REG_DRAG, 32'h0);
                write_reg(REG_BIAS, 32'h0);
                write_reg(REG_THRESHOLD, 32'h0);
                write_reg(REG_GRAV_X, 32'h80000000);
                write_reg(REG_GRAV_Y, 32'h7FFFFFFF);
                write_reg(REG_GRAV_Z, 32'h80000000);
                write_reg(REG_MODE, 32'd0);
            end else if (phase == 1) begin
                // Largest inverse mass and threshold, full drag, extreme gravities and a bias above one.
                write_reg(REG_INV_MASS, 32'hFFFFFFFF);
                write_reg(REG_DRAG, 32'h10000);
                write_reg(REG_BIAS, 32'h1FFFF);
                write_reg(REG_THRESHOLD, 32'hFFFFFFFF);
                write_reg(REG_GRAV_X, 32'h7FFFFFFF);
                write_reg(REG_GRAV_Y, 32'h80000000);
                write_reg(REG_GRAV_Z, 32'h7FFFFFFF);
                write_reg(REG_MODE, 32'd7);
            end else begin
                write_reg(REG_INV_MASS, ($urandom_range(0, 7) == 0) ? $urandom
                                         : $urandom_range(0, 32'h40000));
                write_reg(REG_DRAG, $urandom_range(32'hC000, 32'h10000));
                write_reg(REG_BIAS, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32'h1FFFF)
                                     : $urandom_range(0, 32'h10000));
                write_reg(REG_THRESHOLD, ($urandom_range(0, 5) == 0) ? $urandom
                                          : $urandom_range(0, 32'h40000));
                write_reg(REG_GRAV_X, pick_word());
                write_reg(REG_GRAV_Y, pick_word());
                write_reg(REG_GRAV_Z, pick_word());
                write_reg(REG_MODE, $urandom_range(0, 7));
            end
            for (int n = 0; n < PHASE_LEN; n++)
                queue_cmd(pick_kind(), pick_word(), pick_word(), pick_word());
            // The sender holds off here until every result is back.
            drain();
        end

        drain();
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
